// File: hw/rtl/mi4_pkg.sv
// mi4_pkg: shared types, constants and helpers for the 4x4 matrix inverse core
// no dependencies
`default_nettype none

package mi4_pkg;

    localparam int DATA_W        = 32;
    localparam int ACC_W         = 35;
    localparam int FRAC_BITS_DEF = 16;
    localparam int THRESH_W      = 16;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd7;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [3:0]               step_t;

    // product steps of one 3x3 minor, then the determinant term
    localparam step_t T_EK  = 4'd0;
    localparam step_t T_FH  = 4'd1;
    localparam step_t T_DK  = 4'd2;
    localparam step_t T_FG  = 4'd3;
    localparam step_t T_DH  = 4'd4;
    localparam step_t T_EG  = 4'd5;
    localparam step_t T_AP  = 4'd6;
    localparam step_t T_BQ  = 4'd7;
    localparam step_t T_CS  = 4'd8;
    localparam step_t T_DET = 4'd9;

    localparam acc_t WORD_MAX = acc_t'($signed(32'h7FFF_FFFF));
    localparam acc_t WORD_MIN = acc_t'($signed(32'h8000_0000));

    function automatic word_t sat_word(input acc_t v);
        word_t r;
        if (v > WORD_MAX)
        begin
            r = WORD_MAX[DATA_W-1:0];
        end
        else if (v < WORD_MIN)
        begin
            r = WORD_MIN[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // reduced (row, col) of operand a in the 3x3 minor, packed {r, c}
    function automatic logic [3:0] op_a_pos(input step_t t);
        logic [3:0] p;
        case (t)
            T_EK:    p = {2'd1, 2'd1};
            T_FH:    p = {2'd1, 2'd2};
            T_DK:    p = {2'd1, 2'd0};
            T_FG:    p = {2'd1, 2'd2};
            T_DH:    p = {2'd1, 2'd0};
            T_EG:    p = {2'd1, 2'd1};
            T_AP:    p = {2'd0, 2'd0};
            T_BQ:    p = {2'd0, 2'd1};
            T_CS:    p = {2'd0, 2'd2};
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    // reduced (row, col) of operand b when it is a stored element
    function automatic logic [3:0] op_b_pos(input step_t t);
        logic [3:0] p;
        case (t)
            T_EK:    p = {2'd2, 2'd2};
            T_FH:    p = {2'd2, 2'd1};
            T_DK:    p = {2'd2, 2'd2};
            T_FG:    p = {2'd2, 2'd0};
            T_DH:    p = {2'd2, 2'd1};
            T_EG:    p = {2'd2, 2'd0};
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    // reduced index to full index, skipping the removed row or column
    function automatic logic [1:0] map_idx(input logic [1:0] idx, input logic [1:0] skip);
        logic [1:0] r;
        r = (idx >= skip) ? idx + 2'd1 : idx;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mi4_if.sv
// mi4_if: valid/ready channel interfaces for input, result and config items
// depends on mi4_pkg
`default_nettype none

interface mi4_in_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            row;
    logic [1:0]            col;
    mi4_pkg::word_t        element;
    logic                  last;
    modport source (output valid, row, col, element, last, input ready);
    modport sink   (input valid, row, col, element, last, output ready);
endinterface

interface mi4_out_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            out_row;
    logic [1:0]            out_col;
    mi4_pkg::word_t        result;
    logic                  singular;
    logic                  final_res;
    modport source (output valid, out_row, out_col, result, singular, final_res, input ready);
    modport sink   (input valid, out_row, out_col, result, singular, final_res, output ready);
endinterface

interface mi4_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mi4_pkg::THRESH_W-1:0]    data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mi4_mul.sv
// mi4_mul: shared fixed-point multiplier, registered product, floor shift and saturation
// depends on mi4_pkg
`default_nettype none

module mi4_mul #(
    parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire mi4_pkg::word_t a,
    input  wire mi4_pkg::word_t b,
    output mi4_pkg::word_t      q
);
    import mi4_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam logic signed [PROD_W-1:0] P_MAX = PROD_W'($signed(32'h7FFF_FFFF));
    localparam logic signed [PROD_W-1:0] P_MIN = PROD_W'($signed(32'h8000_0000));

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] shifted;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    always_comb
    begin
        shifted = prod_reg >>> FRAC_BITS;
        if (shifted > P_MAX)
        begin
            q = P_MAX[DATA_W-1:0];
        end
        else if (shifted < P_MIN)
        begin
            q = P_MIN[DATA_W-1:0];
        end
        else
        begin
            q = shifted[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mi4_div.sv
// mi4_div: radix-2 restoring divider, (num * 2^frac) / den truncated, saturated
// depends on mi4_pkg
`default_nettype none

module mi4_div #(
    parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire mi4_pkg::word_t num,
    input  wire mi4_pkg::word_t den,
    output logic                done,
    output mi4_pkg::word_t      q
);
    import mi4_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] Q_POS_MAX = NUM_W'(32'h7FFF_FFFF);
    localparam logic [NUM_W-1:0] Q_NEG_MAX = NUM_W'(33'h0_8000_0000);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [NUM_W-1:0]          work_reg;
    logic [DATA_W-1:0]         rem_reg;
    logic [DATA_W-1:0]         dmag_reg;
    logic                      neg_reg;

    logic signed [NUM_W-1:0]   num_ext;
    logic [NUM_W-1:0]          nmag;
    logic [DATA_W:0]           rem_sh;
    logic                      ge;
    logic [DATA_W:0]           rem_sub;

    always_comb
    begin
        num_ext = NUM_W'(num) <<< FRAC_BITS;
        nmag    = num_ext[NUM_W-1] ? NUM_W'(-num_ext) : NUM_W'(num_ext);
        rem_sh  = {rem_reg, work_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, dmag_reg};
        rem_sub = rem_sh - {1'b0, dmag_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= nmag;
            rem_reg  <= '0;
            dmag_reg <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
            neg_reg  <= num[DATA_W-1] ^ den[DATA_W-1];
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[NUM_W-2:0], ge};
            rem_reg  <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        end
    end

    always_comb
    begin
        done = done_reg;
        if (!neg_reg)
        begin
            q = (work_reg > Q_POS_MAX) ? WORD_MAX[DATA_W-1:0] : work_reg[DATA_W-1:0];
        end
        else
        begin
            q = (work_reg > Q_NEG_MAX) ? WORD_MIN[DATA_W-1:0]
                                       : DATA_W'(~work_reg[DATA_W-1:0] + DATA_W'(1));
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/matrix_inverse_4x4_core.sv
// matrix_inverse_4x4_core: 4x4 fixed-point inverse by cofactors, shared multiplier and divider
// depends on mi4_pkg, mi4_if, mi4_mul, mi4_div
// an item without last is stored; ready stays high in idle, one matrix at a time
// an item with last starts the inverse: 40 det products, then 9 products and a divide per element;
// each product passes S_OPA, S_OPB, S_MUL and S_ACC; a singular matrix skips the element products and divides
// rst_n is asynchronous, active low; it resets control and the threshold (7), not the store
`default_nettype none

module matrix_inverse_4x4_core #(
    parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mi4_in_if.sink    in_ch,
    mi4_out_if.source out_ch,
    mi4_cfg_if.sink   cfg_ch
);
    import mi4_pkg::*;

    // one-hot sequencer states
    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_OPA       = 9'b000000010,
        S_OPB       = 9'b000000100,
        S_MUL       = 9'b000001000,
        S_ACC       = 9'b000010000,
        S_CHECK     = 9'b000100000,
        S_DIV_START = 9'b001000000,
        S_DIV_WAIT  = 9'b010000000,
        S_OUT       = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [THRESH_W-1:0]    thresh_reg;
    logic                   det_mode_reg, det_mode_next;
    logic [3:0]             k_reg, k_next;
    step_t                  t_reg, t_next;
    logic                   sing_reg, sing_next;

    // payload registers
    word_t                  store [16];
    word_t                  rd_reg;
    word_t                  opa_reg, opa_next;
    acc_t                   acc_reg, acc_next;
    acc_t                   dacc_reg, dacc_next;
    word_t                  p_reg, p_next;
    word_t                  q_reg, q_next;
    word_t                  s_reg, s_next;
    word_t                  minor_reg, minor_next;
    word_t                  det_reg, det_next;
    word_t                  result_reg, result_next;

    logic [1:0]             skip_r, skip_c;
    logic [3:0]             pos_a, pos_b;
    logic [3:0]             addr_a, addr_b, rd_addr;
    word_t                  opb_sel;
    word_t                  mul_q;
    word_t                  minor_sum;
    acc_t                   dacc_sum;
    logic [DATA_W:0]        det_mag;
    logic                   div_start;
    logic                   div_done;
    word_t                  div_q;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid     = (state_reg == S_OUT);
    assign out_ch.out_row   = k_reg[3:2];
    assign out_ch.out_col   = k_reg[1:0];
    assign out_ch.result    = result_reg;
    assign out_ch.singular  = sing_reg;
    assign out_ch.final_res = (k_reg == 4'd15);

    // minor selection: row 0 expansion for det, transposed minor for adjugate
    // operand a is read in S_OPA, operand b in S_OPB; read data is registered in rd_reg
    always_comb
    begin
        skip_r  = det_mode_reg ? 2'd0 : k_reg[1:0];
        skip_c  = det_mode_reg ? k_reg[1:0] : k_reg[3:2];
        pos_a   = op_a_pos(t_reg);
        pos_b   = op_b_pos(t_reg);
        addr_a  = (t_reg == T_DET) ? {2'd0, k_reg[1:0]}
                                   : {map_idx(pos_a[3:2], skip_r), map_idx(pos_a[1:0], skip_c)};
        addr_b  = {map_idx(pos_b[3:2], skip_r), map_idx(pos_b[1:0], skip_c)};
        rd_addr = (state_reg == S_OPA) ? addr_a : addr_b;
        // operand b: an intermediate term or the element read in S_OPB
        unique case (t_reg)
            T_AP:    opb_sel = p_reg;
            T_BQ:    opb_sel = q_reg;
            T_CS:    opb_sel = s_reg;
            T_DET:   opb_sel = minor_reg;
            default: opb_sel = rd_reg;
        endcase
    end

    mi4_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk (clk),
        .en  (state_reg == S_MUL),
        .a   (opa_reg),
        .b   (opb_sel),
        .q   (mul_q)
    );

    mi4_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (minor_reg),
        .den   (det_reg),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        det_mode_next = det_mode_reg;
        k_next        = k_reg;
        t_next        = t_reg;
        sing_next     = sing_reg;
        opa_next      = opa_reg;
        acc_next      = acc_reg;
        dacc_next     = dacc_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        s_next        = s_reg;
        minor_next    = minor_reg;
        det_next      = det_reg;
        result_next   = result_reg;
        div_start     = 1'b0;
        minor_sum     = sat_word(acc_reg + acc_t'(mul_q));
        dacc_sum      = k_reg[0] ? dacc_reg - acc_t'(mul_q) : dacc_reg + acc_t'(mul_q);
        det_mag       = det_reg[DATA_W-1] ? (DATA_W+1)'(-acc_t'(det_reg))
                                          : (DATA_W+1)'(det_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                // last item starts the determinant pass
                if (in_ch.valid && in_ch.last)
                begin
                    det_mode_next = 1'b1;
                    k_next        = 4'd0;
                    t_next        = T_EK;
                    dacc_next     = '0;
                    state_next    = S_OPA;
                end
            end
            S_OPA:
            begin
                state_next = S_OPB;
            end
            S_OPB:
            begin
                opa_next   = rd_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                t_next     = t_reg + step_t'(1);
                state_next = S_OPA;
                unique case (t_reg)
                    T_FH: p_next   = sat_word(acc_reg - acc_t'(mul_q));
                    T_FG: q_next   = sat_word(acc_reg - acc_t'(mul_q));
                    T_EG: s_next   = sat_word(acc_reg - acc_t'(mul_q));
                    T_BQ: acc_next = acc_reg - acc_t'(mul_q);
                    T_CS:
                    begin
                        if (det_mode_reg)
                        begin
                            minor_next = minor_sum;
                        end
                        else
                        begin
                            // odd row plus column gets the cofactor sign
                            minor_next = (k_reg[2] ^ k_reg[0]) ? sat_word(-acc_t'(minor_sum))
                                                               : minor_sum;
                            state_next = S_DIV_START;
                        end
                    end
                    T_DET:
                    begin
                        dacc_next = dacc_sum;
                        t_next    = T_EK;
                        if (k_reg[1:0] == 2'd3)
                        begin
                            det_next   = sat_word(dacc_sum);
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            k_next = k_reg + 4'd1;
                        end
                    end
                    default: acc_next = acc_t'(mul_q);
                endcase
            end
            S_CHECK:
            begin
                sing_next     = (det_reg == '0) || (det_mag < (DATA_W+1)'(thresh_reg));
                det_mode_next = 1'b0;
                k_next        = 4'd0;
                t_next        = T_EK;
                result_next   = '0;
                state_next    = ((det_reg == '0) || (det_mag < (DATA_W+1)'(thresh_reg)))
                                ? S_OUT : S_OPA;
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    result_next = div_q;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    if (k_reg == 4'd15)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        t_next     = T_EK;
                        state_next = sing_reg ? S_OUT : S_OPA;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            thresh_reg   <= THRESH_RESET;
            det_mode_reg <= 1'b0;
            k_reg        <= 4'd0;
            t_reg        <= T_EK;
            sing_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            det_mode_reg <= det_mode_next;
            k_reg        <= k_next;
            t_reg        <= t_next;
            sing_reg     <= sing_next;
            if (cfg_ch.valid)
            begin
                thresh_reg <= cfg_ch.data;
            end
        end
    end

    // matrix store and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            store[{in_ch.row, in_ch.col}] <= in_ch.element;
        end
        rd_reg     <= store[rd_addr];
        opa_reg    <= opa_next;
        acc_reg    <= acc_next;
        dacc_reg   <= dacc_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        s_reg      <= s_next;
        minor_reg  <= minor_next;
        det_reg    <= det_next;
        result_reg <= result_next;
    end

    // no item is taken while results are pending
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input ready while result pending");

    // a singular run only ever shows zero results
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.singular) |-> (out_ch.result == '0))
        else $error("nonzero result on singular run");

    // divider completes only when the sequencer waits on it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider done outside wait state");

    // final flag drops back to idle after its handshake
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.final_res) |=> in_ch.ready)
        else $error("not idle after final result");

endmodule

`default_nettype wire

// File: verif/tb_matrix_inverse_4x4_core.sv
// testbench for matrix_inverse_4x4_core: loads matrices, predicts each inverse and checks it
// depends on mi4_pkg, mi4_if and the core rtl
`timescale 1ns / 1ps

module tb_matrix_inverse_4x4_core;

    import mi4_pkg::*;

    localparam int  FRAC         = FRAC_BITS_DEF;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  SETTLE       = 40;
    localparam int  TAIL_CYCLES  = 3000;    // longer than one full inversion
    localparam int  MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        word_t      result;
        logic       singular;
        logic       final_res;
    } inv_elem_t;

    logic clk;
    logic rst_n;

    mi4_in_if  in_ch ();
    mi4_out_if out_ch ();
    mi4_cfg_if cfg_ch ();

    matrix_inverse_4x4_core #(.FRAC_BITS(FRAC)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // own copy of the core state
    longint      shadow_matrix [16];
    int unsigned shadow_thresh;

    inv_elem_t   pending_inverse [$];
    int          mismatches;
    int          cycle_count;
    int          items_sent;

    // idle control for both sides
    bit          no_idle;
    int          out_hold_cycles;
    int          out_stall;

    // ------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // inverse predictor, fixed point on 64-bit integers
    // ------------------------------------------------------------------
    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // full product, floor shift, saturate
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip32(p >>> FRAC);
    endfunction

    // 3x3 minor with one row and one column removed
    function automatic longint minor_of(input int skip_r, input int skip_c);
        int     rs [3];
        int     cs [3];
        int     n;
        longint a, b, c, d, e, f, g, h, k, p, q, s;
        n = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (i != skip_r)
            begin
                rs[n] = i;
                n++;
            end
        end
        n = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (i != skip_c)
            begin
                cs[n] = i;
                n++;
            end
        end
        a = shadow_matrix[rs[0]*4 + cs[0]];
        b = shadow_matrix[rs[0]*4 + cs[1]];
        c = shadow_matrix[rs[0]*4 + cs[2]];
        d = shadow_matrix[rs[1]*4 + cs[0]];
        e = shadow_matrix[rs[1]*4 + cs[1]];
        f = shadow_matrix[rs[1]*4 + cs[2]];
        g = shadow_matrix[rs[2]*4 + cs[0]];
        h = shadow_matrix[rs[2]*4 + cs[1]];
        k = shadow_matrix[rs[2]*4 + cs[2]];
        p = clip32(qmul(e, k) - qmul(f, h));
        q = clip32(qmul(d, k) - qmul(f, g));
        s = clip32(qmul(d, h) - qmul(e, g));
        return clip32(qmul(a, p) - qmul(b, q) + qmul(c, s));
    endfunction

    // store the element, and on last queue the sixteen inverse elements
    task automatic predict_inverse(input logic [1:0] r, input logic [1:0] c,
                                   input word_t e, input logic is_last);
        longint    det;
        longint    mag;
        longint    adj;
        longint    res;
        bit        sing;
        inv_elem_t x;
        shadow_matrix[{r, c}] = longint'(e);
        if (is_last)
        begin
            det = clip32(qmul(shadow_matrix[0], minor_of(0, 0))
                       - qmul(shadow_matrix[1], minor_of(0, 1))
                       + qmul(shadow_matrix[2], minor_of(0, 2))
                       - qmul(shadow_matrix[3], minor_of(0, 3)));
            mag  = (det < 0) ? -det : det;
            // zero determinant is singular even with threshold 0
            sing = (det == 0) || (mag < longint'(shadow_thresh));
            for (int idx = 0; idx < 16; idx++)
            begin
                res = 0;
                if (!sing)
                begin
                    // adjugate is the transposed cofactor
                    adj = minor_of(idx % 4, idx / 4);
                    if (((idx / 4) + (idx % 4)) % 2 == 1)
                    begin
                        adj = clip32(-adj);
                    end
                    res = clip32((adj * (64'sd1 <<< FRAC)) / det);
                end
                x.row       = 2'(idx / 4);
                x.col       = 2'(idx % 4);
                x.result    = word_t'(res);
                x.singular  = sing;
                x.final_res = (idx == 15);
                pending_inverse.push_back(x);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side: ready with random stalls, long hold on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (out_hold_cycles > 0)
        begin
            out_ch.ready = 1'b0;
            out_hold_cycles--;
        end
        else if (no_idle)
        begin
            out_ch.ready = 1'b1;
        end
        else if (out_stall > 0)
        begin
            out_ch.ready = 1'b0;
            out_stall--;
        end
        else if ($urandom_range(0, 9) < 2)
        begin
            // mostly short stalls, now and then a long one
            out_stall    = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                      : $urandom_range(10, 60);
            out_ch.ready = 1'b0;
        end
        else
        begin
            out_ch.ready = 1'b1;
        end
    end

    // compare each accepted result with the oldest expected one
    always @(posedge clk)
    begin
        inv_elem_t want;
        inv_elem_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.row       = out_ch.out_row;
            got.col       = out_ch.out_col;
            got.result    = out_ch.result;
            got.singular  = out_ch.singular;
            got.final_res = out_ch.final_res;
            if (pending_inverse.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected item: row %0d col %0d result %h sing %b final %b",
                             got.row, got.col, got.result, got.singular, got.final_res);
                end
            end
            else
            begin
                want = pending_inverse.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected row %0d col %0d result %h sing %b final %b",
                                 want.row, want.col, want.result, want.singular,
                                 want.final_res);
                        $display("          actual   row %0d col %0d result %h sing %b final %b",
                                 got.row, got.col, got.result, got.singular, got.final_res);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (no_idle || roll < 13)
        begin
            return 0;
        end
        if (roll < 19)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    // one input item; valid stays high into the next call unless a gap is drawn
    task automatic send_item(input logic [1:0] r, input logic [1:0] c,
                             input word_t e, input logic is_last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.row     = r;
        in_ch.col     = c;
        in_ch.element = e;
        in_ch.last    = is_last;
        in_ch.valid   = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        predict_inverse(r, c, e, is_last);
        items_sent++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // sender stops until every expected item has come, then lets the core settle
    task automatic wait_drained();
        release_input();
        while (pending_inverse.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        @(negedge clk);
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        shadow_thresh = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // element values: mostly moderate so inverses are meaningful, some full range
    function automatic word_t rand_element();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
        begin
            return word_t'(int'($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
        end
        if (roll < 8)
        begin
            return word_t'($urandom);
        end
        if (roll < 9)
        begin
            return word_t'((int'($urandom_range(0, 8)) - 4) <<< FRAC);
        end
        return ($urandom_range(0, 1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    // a full matrix in shuffled order, last on the final load
    task automatic send_full_matrix();
        int order [16];
        int j;
        int t;
        for (int i = 0; i < 16; i++)
        begin
            order[i] = i;
        end
        for (int i = 15; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < 16; i++)
        begin
            send_item(2'(order[i] / 4), 2'(order[i] % 4), rand_element(), i == 15);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // identity at the reset threshold, then a zero row with threshold 0
    task automatic test_directed();
        no_idle = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            send_item(2'(i / 4), 2'(i % 4),
                      (i / 4 == i % 4) ? word_t'(32'sh0001_0000) : word_t'(0), i == 15);
        end
        wait_drained();
        no_idle = 1'b0;
        write_threshold(16'd0);
        for (int i = 0; i < 4; i++)
        begin
            send_item(2'd0, 2'(i), word_t'(0), i == 3);
        end
        wait_drained();
        // extremes of the element field, saturation along the way
        send_item(2'd0, 2'd0, 32'sh7FFF_FFFF, 1'b0);
        send_item(2'd1, 2'd1, 32'sh8000_0000, 1'b0);
        send_item(2'd2, 2'd2, 32'sh7FFF_FFFF, 1'b0);
        send_item(2'd3, 2'd3, 32'sh0000_0001, 1'b1);
        wait_drained();
    endtask

    // max threshold makes a half-scale diagonal singular, small one does not
    task automatic test_threshold();
        write_threshold(16'hFFFF);
        for (int i = 0; i < 16; i++)
        begin
            send_item(2'(i / 4), 2'(i % 4),
                      (i / 4 == i % 4) ? word_t'(32'sh0000_8000) : word_t'(0), i == 15);
        end
        wait_drained();
        write_threshold(16'd1);
        send_item(2'd3, 2'd3, word_t'(32'sh0000_8000), 1'b1);
        wait_drained();
    endtask

    // input stalls while results are held, then the sender waits for all of them
    task automatic test_backpressure();
        out_hold_cycles = 4000;
        send_full_matrix();
        for (int i = 0; i < 6; i++)
        begin
            send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      rand_element(), i == 5);
        end
        wait_drained();
    endtask

    task automatic test_random(input int target);
        int phase;
        int n;
        phase = 0;
        while (items_sent < target)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                send_full_matrix();
            end
            else
            begin
                // partial reload, random positions, any item may trigger
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                begin
                    send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              rand_element(), ($urandom_range(0, 2) == 0) || (i == n - 1));
                end
            end
            phase++;
            if (phase % 4 == 0)
            begin
                wait_drained();
                case ($urandom_range(0, 3))
                    0:       write_threshold(16'd0);
                    1:       write_threshold(16'hFFFF);
                    2:       write_threshold(THRESH_RESET);
                    default: write_threshold(16'($urandom));
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.row       = '0;
        in_ch.col       = '0;
        in_ch.element   = '0;
        in_ch.last      = 1'b0;
        out_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        mismatches      = 0;
        cycle_count     = 0;
        items_sent      = 0;
        no_idle         = 1'b0;
        out_hold_cycles = 0;
        out_stall       = 0;
        shadow_thresh   = THRESH_RESET;
        for (int i = 0; i < 16; i++)
        begin
            shadow_matrix[i] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (5) @(negedge clk);

        test_directed();
        test_threshold();
        test_backpressure();
        test_random(220);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_inverse.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
